[rtl/core/hps_pkg.sv]
// Shared types and constants for the host/port address splitter.
`timescale 1ns / 1ps

package hps_pkg;

  localparam int MAX_LEN = 256;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int HLEN_W  = 9;
  localparam int PORT_W  = 16;
  localparam int ACC_W   = 17;
  localparam int CNT_W   = 3;

  localparam logic [ACC_W-1:0] PORT_MAX   = ACC_W'(65535);
  localparam logic [CNT_W-1:0] PORT_DIGITS = CNT_W'(5);

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_BR_HOST  = 3'd1,
    MODE_BR_AFTER = 3'd2,
    MODE_BR_PORT  = 3'd3,
    MODE_BR_JUNK  = 3'd4,
    MODE_PL_HOST  = 3'd5,
    MODE_PL_PORT  = 3'd6,
    MODE_PL_MULTI = 3'd7
  } mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
    logic       empty_marker;
  } char_item_t;

  typedef struct packed {
    logic              valid_res;
    logic              host_offset;
    logic [HLEN_W-1:0] host_length;
    logic              port_given;
    logic [PORT_W-1:0] port_value;
  } res_item_t;

endpackage

[rtl/core/host_port_splitter_top.sv]
// Top level of the host/port address splitter: handshakes and result buffering.
`timescale 1ns / 1ps

// Takes one address character per cycle while char_ready is high and produces one
// result item per string, on the item marked last or on an empty-string item. The
// parse state updates on each accepted character; the result is registered into the
// output register, or into the skid entry while the output register is held. A result
// register plus one skid entry sit on the output, so char_ready drops only when two
// results are waiting to be taken. Strings longer than MAX_LEN characters are
// rejected; host and port fields read as zero on a rejected address.
module host_port_splitter_top
  import hps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  char_item_t char_item,
  output logic       res_valid,
  input  logic       res_ready,
  output res_item_t  res_item
);

  logic      take;
  logic      new_fire;
  res_item_t new_res;
  logic      skid_valid;
  res_item_t skid;

  assign char_ready = !skid_valid;
  assign take       = char_valid && char_ready;

  hps_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (char_item),
    .res_fire (new_fire),
    .res      (new_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      // output slot frees: drain skid first, then the fresh item
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= new_fire;
      end
    end else if (new_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      res_item <= skid_valid ? skid : new_res;
    end else if (new_fire) begin
      skid <= new_res;
    end
  end

endmodule

[rtl/core/hps_parser.sv]
// Per-character parse state and end-of-string result evaluation.
`timescale 1ns / 1ps

module hps_parser
  import hps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  char_item_t item,
  output logic       res_fire,
  output res_item_t  res
);

  mode_t             mode, mode_next;
  logic [POS_W-1:0]  char_pos, char_pos_next;
  logic [POS_W-1:0]  colon_pos, colon_pos_next;
  logic [POS_W-1:0]  close_pos, close_pos_next;
  logic [ACC_W-1:0]  port_acc, port_acc_next;
  logic [CNT_W-1:0]  port_cnt, port_cnt_next;
  logic              port_bad, port_bad_next;
  logic              len_ovf, len_ovf_next;

  logic              is_digit;
  logic              take_port;
  logic              port_ok;
  logic [7:0]        c;

  assign c        = item.char_code;
  assign is_digit = c inside {[CH_ZERO:CH_NINE]};

  // next mode
  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_START: begin
        if (c == CH_COLON) begin
          mode_next = MODE_PL_PORT;
        end else if (c == CH_LBRACKET) begin
          mode_next = MODE_BR_HOST;
        end else begin
          mode_next = MODE_PL_HOST;
        end
      end
      MODE_BR_HOST: begin
        if (c == CH_RBRACKET) mode_next = MODE_BR_AFTER;
      end
      MODE_BR_AFTER: begin
        mode_next = (c == CH_COLON) ? MODE_BR_PORT : MODE_BR_JUNK;
      end
      MODE_PL_HOST: begin
        if (c == CH_COLON) mode_next = MODE_PL_PORT;
      end
      MODE_PL_PORT: begin
        if (c == CH_COLON) mode_next = MODE_PL_MULTI;
      end
      default: mode_next = mode;
    endcase
  end

  // position, colon, bracket and port datapath
  always_comb begin
    len_ovf_next   = len_ovf;
    char_pos_next  = char_pos;
    colon_pos_next = colon_pos;
    close_pos_next = close_pos;
    port_acc_next  = port_acc;
    port_cnt_next  = port_cnt;
    port_bad_next  = port_bad;

    if (char_pos >= POS_W'(MAX_LEN)) begin
      len_ovf_next = 1'b1;
    end else begin
      char_pos_next = char_pos + POS_W'(1);
    end

    if ((mode == MODE_START || mode == MODE_PL_HOST) && c == CH_COLON) begin
      colon_pos_next = char_pos;
    end
    if (mode == MODE_BR_HOST && c == CH_RBRACKET) begin
      close_pos_next = char_pos;
    end

    take_port = (mode == MODE_BR_PORT) || (mode == MODE_PL_PORT && c != CH_COLON);
    if (take_port) begin
      if (!is_digit || port_cnt >= PORT_DIGITS) begin
        port_bad_next = 1'b1;
      end else begin
        port_acc_next = (port_acc << 3) + (port_acc << 1) + ACC_W'(c - CH_ZERO);
        port_cnt_next = port_cnt + CNT_W'(1);
      end
    end
  end

  // result from the updated state
  always_comb begin
    port_ok = !port_bad_next && port_cnt_next != '0 &&
              port_acc_next != '0 && port_acc_next <= PORT_MAX;
    res = '0;
    if (!item.empty_marker && !len_ovf_next) begin
      case (mode_next)
        MODE_BR_AFTER, MODE_BR_PORT: begin
          if (close_pos_next >= POS_W'(2)) begin
            if (mode_next == MODE_BR_AFTER || port_ok) begin
              res.valid_res   = 1'b1;
              res.host_offset = 1'b1;
              res.host_length = HLEN_W'(close_pos_next - POS_W'(1));
              if (mode_next == MODE_BR_PORT) begin
                res.port_given = 1'b1;
                res.port_value = port_acc_next[PORT_W-1:0];
              end
            end
          end
        end
        MODE_PL_HOST, MODE_PL_MULTI: begin
          res.valid_res   = 1'b1;
          res.host_length = HLEN_W'(char_pos_next);
        end
        MODE_PL_PORT: begin
          if (colon_pos_next != '0 && port_ok) begin
            res.valid_res   = 1'b1;
            res.host_length = HLEN_W'(colon_pos_next);
            res.port_given  = 1'b1;
            res.port_value  = port_acc_next[PORT_W-1:0];
          end
        end
        default: res = '0;
      endcase
    end
  end

  assign res_fire = take && (item.is_last || item.empty_marker);

  always_ff @(posedge clk) begin
    if (rst || res_fire) begin
      mode      <= MODE_START;
      char_pos  <= '0;
      colon_pos <= '0;
      close_pos <= '0;
      port_acc  <= '0;
      port_cnt  <= '0;
      port_bad  <= 1'b0;
      len_ovf   <= 1'b0;
    end else if (take) begin
      mode      <= mode_next;
      char_pos  <= char_pos_next;
      colon_pos <= colon_pos_next;
      close_pos <= close_pos_next;
      port_acc  <= port_acc_next;
      port_cnt  <= port_cnt_next;
      port_bad  <= port_bad_next;
      len_ovf   <= len_ovf_next;
    end
  end

endmodule

[test/host_port_checker.sv]
// Predictor and scoreboard for the host/port splitter: watches both channels and compares.
`timescale 1ns / 1ps

module host_port_checker
  import hps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_ready,
  input  char_item_t  char_item,
  input  logic        res_valid,
  input  logic        res_ready,
  input  res_item_t   res_item,
  output int unsigned mismatch_count,
  output int unsigned results_pending
);

  mode_t             mode;
  logic [POS_W-1:0]  len_so_far;
  logic [POS_W-1:0]  colon_at;
  logic [POS_W-1:0]  close_at;
  logic [ACC_W-1:0]  port_acc;
  logic [CNT_W-1:0]  port_digits;
  logic              port_bad;
  logic              too_long;

  res_item_t expected_splits[$];
  res_item_t split_now;
  res_item_t oldest_split;
  bit        split_done;

  function automatic void clear_parse();
    mode        = MODE_START;
    len_so_far  = '0;
    colon_at    = '0;
    close_at    = '0;
    port_acc    = '0;
    port_digits = '0;
    port_bad    = 1'b0;
    too_long    = 1'b0;
  endfunction

  function automatic void take_port_digit(input logic [7:0] c);
    if (c < CH_ZERO || c > CH_NINE || port_digits >= PORT_DIGITS) begin
      port_bad = 1'b1;
      return;
    end
    port_acc    = port_acc * ACC_W'(10) + ACC_W'(c - CH_ZERO);
    port_digits = port_digits + CNT_W'(1);
  endfunction

  function automatic bit port_usable();
    return !port_bad && port_digits != '0 && port_acc != '0 && port_acc <= PORT_MAX;
  endfunction

  // Advance the parse by one character; produce a split on the closing item.
  function automatic void split_char(input char_item_t it, output bit produced,
                                     output res_item_t r);
    logic [POS_W-1:0] pos;
    logic [7:0]       c;
    bit               ok;
    r        = '0;
    ok       = 1'b0;
    produced = 1'b0;
    c        = it.char_code;
    if (it.empty_marker) begin
      produced = 1'b1;
      clear_parse();
      return;
    end
    pos = len_so_far;
    if (pos >= POS_W'(MAX_LEN)) begin
      too_long = 1'b1;
    end else begin
      len_so_far = pos + POS_W'(1);
    end
    case (mode)
      MODE_START: begin
        mode = (c == CH_LBRACKET) ? MODE_BR_HOST : MODE_PL_HOST;
        if (c == CH_COLON) begin
          colon_at = pos;
          mode     = MODE_PL_PORT;
        end
      end
      MODE_BR_HOST: begin
        if (c == CH_RBRACKET) begin
          close_at = pos;
          mode     = MODE_BR_AFTER;
        end
      end
      MODE_BR_AFTER: mode = (c == CH_COLON) ? MODE_BR_PORT : MODE_BR_JUNK;
      MODE_BR_PORT:  take_port_digit(c);
      MODE_PL_HOST: begin
        if (c == CH_COLON) begin
          colon_at = pos;
          mode     = MODE_PL_PORT;
        end
      end
      MODE_PL_PORT: begin
        if (c == CH_COLON) begin
          mode = MODE_PL_MULTI;
        end else begin
          take_port_digit(c);
        end
      end
      default: ;
    endcase
    if (!it.is_last) return;
    produced = 1'b1;
    if (!too_long) begin
      case (mode)
        MODE_BR_AFTER, MODE_BR_PORT: begin
          if (close_at >= POS_W'(2)) begin
            r.host_offset = 1'b1;
            r.host_length = HLEN_W'(close_at - POS_W'(1));
            if (mode == MODE_BR_AFTER) begin
              ok = 1'b1;
            end else if (port_usable()) begin
              ok           = 1'b1;
              r.port_given = 1'b1;
              r.port_value = PORT_W'(port_acc);
            end
          end
        end
        MODE_PL_HOST, MODE_PL_MULTI: begin
          ok            = 1'b1;
          r.host_length = HLEN_W'(len_so_far);
        end
        MODE_PL_PORT: begin
          if (colon_at != '0 && port_usable()) begin
            ok            = 1'b1;
            r.host_length = HLEN_W'(colon_at);
            r.port_given  = 1'b1;
            r.port_value  = PORT_W'(port_acc);
          end
        end
        default: ;
      endcase
    end
    if (ok) begin
      r.valid_res = 1'b1;
    end else begin
      r = '0;
    end
    clear_parse();
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_splits.delete();
      mismatch_count = 0;
    end else begin
      if (char_valid && char_ready) begin
        split_char(char_item, split_done, split_now);
        if (split_done) expected_splits.push_back(split_now);
      end
      if (res_valid && res_ready) begin
        if (expected_splits.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %h", $time, res_item);
          mismatch_count++;
        end else begin
          oldest_split = expected_splits.pop_front();
          check_field("valid_res", oldest_split.valid_res, res_item.valid_res);
          check_field("host_offset", oldest_split.host_offset, res_item.host_offset);
          check_field("host_length", oldest_split.host_length, res_item.host_length);
          check_field("port_given", oldest_split.port_given, res_item.port_given);
          check_field("port_value", oldest_split.port_value, res_item.port_value);
        end
      end
    end
    results_pending = expected_splits.size();
  end

endmodule

[test/tb_host_port_splitter_top.sv]
// Testbench top for the host/port splitter: clock, reset, address stimulus and verdict.
`timescale 1ns / 1ps

module tb_host_port_splitter_top
  import hps_pkg::*;
();

  logic       clk;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_item_t char_item = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  res_item_t  res_item;

  int unsigned mismatch_count;
  int unsigned results_pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned chars_sent = 0;

  logic [7:0] char_buf[$];
  bit         close_with_empty;

  int unsigned idle_by_phase[4]  = '{0, 53, 0, 14};
  int unsigned stall_by_phase[4] = '{0, 0, 53, 14};

  host_port_splitter_top u_top (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  host_port_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_ready      (char_ready),
    .char_item       (char_item),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_item        (res_item),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: a long hold-off overrides the random stalls while it runs.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #5000000;
    $display("host_port_splitter_top verification failed");
    $finish;
  end

  function automatic string pick_chars(input string alphabet, input int unsigned n);
    string s;
    int unsigned j;
    s = "";
    for (int i = 0; i < n; i++) begin
      j = $urandom_range(0, alphabet.len() - 1);
      s = {s, alphabet.substr(j, j)};
    end
    return s;
  endfunction

  function automatic string host_text(input int unsigned n);
    return pick_chars("abcdefghijklmnopqrstuvwxyz0123456789.-", n);
  endfunction

  function automatic string ipv6_text(input int unsigned n);
    return pick_chars("0123456789abcdef:", n);
  endfunction

  function automatic string port_text();
    case ($urandom_range(0, 11))
      0: return "0";
      1: return "65535";
      2: return "65536";
      3: return "99999";
      4: return "1";
      5: return "";
      6: return $sformatf("%06d", $urandom_range(0, 999999));
      7: return {$sformatf("%0d", $urandom_range(0, 99)), pick_chars("/;a] ", 1), "0"};
      8: return "00080";
      default: return $sformatf("%0d", $urandom_range(1, 65535));
    endcase
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
  endfunction

  // Fill char_buf with one address: mostly well-formed, some broken, some noise.
  function automatic void gen_address();
    int unsigned k;
    char_buf.delete();
    close_with_empty = 1'b0;
    k = $urandom_range(0, 99);
    if (k < 18) begin
      add_text(host_text($urandom_range(1, 12)));
    end else if (k < 38) begin
      add_text({host_text($urandom_range(1, 10)), ":", port_text()});
    end else if (k < 58) begin
      add_text({"[", ipv6_text($urandom_range(1, 10)), "]"});
      if ($urandom_range(0, 3) != 0) add_text({":", port_text()});
    end else if (k < 66) begin
      add_text({ipv6_text($urandom_range(0, 4)), ":", ipv6_text($urandom_range(0, 4)), ":",
                ipv6_text($urandom_range(0, 6))});
    end else if (k < 78) begin
      case ($urandom_range(0, 4))
        0: add_text({"[", ipv6_text($urandom_range(0, 6))});
        1: add_text({"[]", pick_chars(":", $urandom_range(0, 1)), port_text()});
        2: add_text({"[", ipv6_text($urandom_range(0, 5)), "]", host_text($urandom_range(1, 3))});
        3: add_text({"[", ipv6_text($urandom_range(1, 5)), "]]"});
        default: add_text({":", port_text()});
      endcase
    end else if (k < 90) begin
      for (int i = $urandom_range(1, 12); i > 0; i--) begin
        if ($urandom_range(0, 1)) begin
          char_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
          add_text(pick_chars("[]:0123456789", 1));
        end
      end
    end else begin
      close_with_empty = 1'b1;
      if ($urandom_range(0, 1)) add_text(host_text($urandom_range(1, 6)));
    end
  endfunction

  // Hold valid across accepted items unless an idle gap is drawn.
  task automatic send_item(input char_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    do @(negedge clk); while (!char_ready);
    @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_address();
    char_item_t it;
    for (int i = 0; i < char_buf.size(); i++) begin
      it.char_code    = char_buf[i];
      it.is_last      = !close_with_empty && (i == char_buf.size() - 1);
      it.empty_marker = 1'b0;
      send_item(it);
    end
    if (close_with_empty) begin
      it.char_code    = 8'($urandom_range(0, 255));
      it.is_last      = 1'($urandom_range(0, 1));
      it.empty_marker = 1'b1;
      send_item(it);
    end
  endtask

  task automatic send_text(input string s);
    char_buf.delete();
    close_with_empty = 1'b0;
    add_text(s);
    send_address();
  endtask

  task automatic send_empty_after(input string partial);
    char_buf.delete();
    close_with_empty = 1'b1;
    add_text(partial);
    send_address();
  endtask

  // Pause the sender until every expected result has been taken.
  task automatic wait_for_results();
    char_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_empty_after("");
    send_text("x");
    send_text("[a]");
    send_text("[]");
    send_text("[]:80");
    send_text("[::1]:65535");
    send_text("[ab]:0");
    send_text("[ab]:65536");
    send_text("[ab]:123456");
    send_text("[ab]:");
    send_text("[ab]x");
    send_text("[ab");
    send_text("[a]]");
    send_text(":80");
    send_text(":");
    send_text("::");
    send_text("h:");
    send_text("h:1");
    send_text("h:8a");
    send_text("a:b:c");
    send_text("ab:99999");
    send_text("ab:00080");
    send_empty_after("abc");
    wait_for_results();

    // Longest accepted host, then one character too many.
    send_text(host_text(MAX_LEN));
    send_text(host_text(MAX_LEN + 1));
    send_text({"[", ipv6_text(MAX_LEN - 2), "]"});
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      // Block the result side for a while so results back up into the input.
      if (ph == 0 || ph == 3) hold_left = 300;
      for (int n = 0; n < 80; ) begin
        gen_address();
        n += char_buf.size() + close_with_empty;
        send_address();
        if (ph == 2 && n >= 40 && n < 40 + 20) wait_for_results();
      end
      wait_for_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("host_port_splitter_top verification clean");
    end else begin
      $display("host_port_splitter_top verification failed");
    end
    $finish;
  end

endmodule

[host_port_splitter_top.f]
rtl/core/hps_pkg.sv
rtl/core/hps_parser.sv
rtl/core/host_port_splitter_top.sv
test/host_port_checker.sv
test/tb_host_port_splitter_top.sv
